// ===== rtl/sfr_pkg.sv =====
// Shared types and constants for the stream find-and-replace block.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  localparam int MAX_PATTERN_DEF = 8;
  localparam int MAX_REPLACE_DEF = 8;

  localparam logic [7:0] NEWLINE = 8'h0A;

  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [1:0] REG_PATTERN_BYTES = 2'd0;
  localparam logic [1:0] REG_PATTERN_LEN   = 2'd1;
  localparam logic [1:0] REG_REPLACE_BYTES = 2'd2;
  localparam logic [1:0] REG_REPLACE_LEN   = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/stream_find_replace_top.sv =====
// Stream find-and-replace: holds possible match bytes and rewrites the text stream.
//
// Request channel (req_valid/req_stall/req_data) takes one item: a text byte or
// an end-of-input flush. Response channel (rsp_valid/rsp_stall/rsp_data) returns
// the rewritten bytes one per transaction, with last set on the final byte that
// an item produces; an item may produce none. Config port (cfg_valid/cfg_ready)
// writes pattern_bytes, pattern_len, replace_bytes, replace_len by index 0..3;
// any write drops the held bytes.
// A data byte is accepted, then the shared MAX_PATTERN-byte prefix comparator
// drops leading window bytes until the rest is a pattern prefix; those bytes,
// or the replacement on a full match, are then emitted. A flush emits the held
// bytes and a newline if a line is open. The block accepts one item at a time;
// req_stall stays high until the item's last byte is loaded into the output
// register, so a stalled receiver holds the sequencer and the next item waits
// behind it. Synchronous reset clears the held count, the open-line flag, the
// output valid flag and the configuration (pattern length 1, empty replacement).
`timescale 1ns / 1ps
`default_nettype none

module stream_find_replace_top #(
  parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_stall,
  input  wire sfr_pkg::req_t req_data,
  output logic              rsp_valid,
  input  wire logic         rsp_stall,
  output sfr_pkg::rsp_t     rsp_data,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);

  localparam int PL_W = $clog2(MAX_PATTERN + 1);
  localparam int HI_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int RL_W = $clog2(MAX_REPLACE + 1);
  localparam int RI_W = (MAX_REPLACE > 1) ? $clog2(MAX_REPLACE) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_HELD = 3'd2;
  localparam logic [2:0] S_REP  = 3'd3;
  localparam logic [2:0] S_NL   = 3'd4;

  logic [2:0]  state;
  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_len;
  logic [63:0] replace_bytes;
  logic [3:0]  replace_len;

  logic [7:0]      held [MAX_PATTERN];
  logic [7:0]      win  [MAX_PATTERN];
  logic [HI_W-1:0] held_count;
  logic            line_open;
  logic [PL_W-1:0] wlen;
  logic [PL_W-1:0] s;
  logic [PL_W-1:0] ecnt;
  logic [RI_W-1:0] rcnt;
  logic            nl_after;

  logic [PL_W-1:0] plen;
  logic [RL_W-1:0] rlen;
  logic [PL_W-1:0] hmin;
  logic [HI_W-1:0] hidx;
  logic            same;
  logic            has_nl;
  logic            mism;
  logic            ok;
  logic            full;
  logic            acc;
  logic            cfg_wr;
  logic            rsp_free;
  logic [7:0]      rep_byte;

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign acc       = req_valid && !req_stall;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign rep_byte  = replace_bytes[8*rcnt +: 8];

  always_comb begin
    if (pattern_len == 4'd0) begin
      plen = PL_W'(1);
    end else if (pattern_len > 4'(MAX_PATTERN)) begin
      plen = PL_W'(MAX_PATTERN);
    end else begin
      plen = PL_W'(pattern_len);
    end
    if (replace_len > 4'(MAX_REPLACE)) begin
      rlen = RL_W'(MAX_REPLACE);
    end else begin
      rlen = RL_W'(replace_len);
    end
    hmin = (PL_W'(held_count) > plen - PL_W'(1)) ? plen - PL_W'(1) : PL_W'(held_count);
    hidx = HI_W'(hmin);
  end

  // pattern-wide checks and the shared prefix comparator
  always_comb begin
    same   = (4'(plen) == 4'(rlen));
    has_nl = 1'b0;
    mism   = 1'b0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (PL_W'(i) < plen) begin
        if (pattern_bytes[8*i +: 8] != replace_bytes[8*i +: 8]) same = 1'b0;
        if (pattern_bytes[8*i +: 8] == sfr_pkg::NEWLINE) has_nl = 1'b1;
      end
      if (PL_W'(i) < wlen && win[i] != pattern_bytes[8*i +: 8]) mism = 1'b1;
    end
    ok   = (wlen == '0) || (!mism && !has_nl);
    full = (s == '0) && (wlen == plen);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pattern_bytes <= '0;
      pattern_len   <= 4'd1;
      replace_bytes <= '0;
      replace_len   <= 4'd0;
      held_count    <= '0;
      line_open     <= 1'b0;
      rsp_valid     <= 1'b0;
      wlen          <= '0;
      s             <= '0;
      ecnt          <= '0;
      rcnt          <= '0;
      nl_after      <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      if (cfg_wr) begin
        case (cfg_index)
          sfr_pkg::REG_PATTERN_BYTES: pattern_bytes <= cfg_data;
          sfr_pkg::REG_PATTERN_LEN:   pattern_len   <= cfg_data[3:0];
          sfr_pkg::REG_REPLACE_BYTES: replace_bytes <= cfg_data;
          sfr_pkg::REG_REPLACE_LEN:   replace_len   <= cfg_data[3:0];
          default: ;
        endcase
        held_count <= '0;
      end
      case (state)
        S_IDLE: begin
          if (acc && !same) begin
            if (req_data.req_type == sfr_pkg::REQ_FLUSH) begin
              ecnt       <= PL_W'(held_count);
              nl_after   <= line_open;
              held_count <= '0;
              line_open  <= 1'b0;
              if (held_count != '0) begin
                state <= S_HELD;
              end else if (line_open) begin
                state <= S_NL;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              line_open <= (req_data.data_byte != sfr_pkg::NEWLINE);
              wlen      <= hmin + PL_W'(1);
              s         <= '0;
              nl_after  <= 1'b0;
              state     <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (ok && full) begin
            held_count <= '0;
            rcnt       <= '0;
            state      <= (rlen != '0) ? S_REP : S_IDLE;
          end else if (ok) begin
            held_count <= HI_W'(wlen);
            ecnt       <= s;
            state      <= (s != '0) ? S_HELD : S_IDLE;
          end else begin
            wlen <= wlen - PL_W'(1);
            s    <= s + PL_W'(1);
          end
        end
        S_HELD: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            ecnt      <= ecnt - PL_W'(1);
            if (ecnt == PL_W'(1)) state <= nl_after ? S_NL : S_IDLE;
          end
        end
        S_REP: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            rcnt      <= rcnt + RI_W'(1);
            if (RL_W'(rcnt) == rlen - RL_W'(1)) state <= S_IDLE;
          end
        end
        S_NL: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // held store, search window and output payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (acc && !same && req_data.req_type == sfr_pkg::REQ_DATA) begin
          held[hidx] <= req_data.data_byte;
          for (int i = 0; i < MAX_PATTERN; i++) begin
            win[i] <= (HI_W'(i) == hidx) ? req_data.data_byte : held[i];
          end
        end
      end
      S_SRCH: begin
        if (!ok) begin
          for (int i = 0; i < MAX_PATTERN - 1; i++) win[i] <= win[i+1];
        end
      end
      S_HELD: begin
        if (rsp_free) begin
          rsp_data.out_byte <= held[0];
          rsp_data.last     <= (ecnt == PL_W'(1)) && !nl_after;
          for (int i = 0; i < MAX_PATTERN - 1; i++) held[i] <= held[i+1];
        end
      end
      S_REP: begin
        if (rsp_free) begin
          rsp_data.out_byte <= rep_byte;
          rsp_data.last     <= (RL_W'(rcnt) == rlen - RL_W'(1));
        end
      end
      S_NL: begin
        if (rsp_free) begin
          rsp_data.out_byte <= sfr_pkg::NEWLINE;
          rsp_data.last     <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== verif/stream_find_replace_top_tb.sv =====
// Self-checking testbench for stream_find_replace_top with an in-bench rewrite predictor.
`timescale 1ns / 1ps

module stream_find_replace_top_tb;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  sfr_pkg::req_t req_data = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  sfr_pkg::rsp_t rsp_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [1:0]    cfg_index = sfr_pkg::REG_PATTERN_BYTES;
  logic [63:0]   cfg_data = '0;

  stream_find_replace_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers and the hold-back state
  logic [63:0] pat_bytes_m = '0;
  logic [3:0]  pat_len_m   = 4'd1;
  logic [63:0] rep_bytes_m = '0;
  logic [3:0]  rep_len_m   = 4'd0;
  logic [7:0]  held_m [0:7];
  int          held_cnt_m  = 0;
  bit          line_open_m = 1'b0;

  sfr_pkg::req_t pending_items_q[$];
  sfr_pkg::rsp_t expected_bytes_q[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  int hold_left      = 0;
  bit hold_armed     = 1'b0;
  bit hold_used      = 1'b0;
  bit quiet          = 1'b0;

  function automatic int eff_pattern_len();
    if (pat_len_m == 4'd0) return 1;
    if (pat_len_m > 4'd8) return 8;
    return int'(pat_len_m);
  endfunction

  function automatic logic [7:0] pat_byte(int i);
    return pat_bytes_m[8*i +: 8];
  endfunction

  // Expected output bytes for one accepted transaction; updates the hold-back state.
  function automatic void predict_rewrite(sfr_pkg::req_t item);
    logic [7:0] line_buf [0:8];
    logic [7:0] emit [0:15];
    logic [7:0] c;
    int n, plen, rlen, len, s, i;
    bit same, has_nl, full, ok;
    sfr_pkg::rsp_t r;
    n = 0;
    plen = eff_pattern_len();
    rlen = (rep_len_m > 4'd8) ? 8 : int'(rep_len_m);
    same = (plen == rlen);
    has_nl = 1'b0;
    for (i = 0; i < plen; i++) begin
      if (pat_byte(i) != rep_bytes_m[8*i +: 8]) same = 1'b0;
      if (pat_byte(i) == sfr_pkg::NEWLINE) has_nl = 1'b1;
    end
    if (same) return;
    if (item.req_type == sfr_pkg::REQ_FLUSH) begin
      for (i = 0; i < held_cnt_m; i++) begin
        emit[n] = held_m[i];
        n++;
      end
      if (line_open_m) begin
        emit[n] = sfr_pkg::NEWLINE;
        n++;
      end
      held_cnt_m = 0;
      line_open_m = 1'b0;
    end else begin
      c = item.data_byte;
      line_open_m = (c != sfr_pkg::NEWLINE);
      if (has_nl) begin
        emit[n] = c;
        n++;
      end else begin
        len = (held_cnt_m >= plen) ? plen - 1 : held_cnt_m;
        for (i = 0; i < len; i++) line_buf[i] = held_m[i];
        line_buf[len] = c;
        len++;
        full = (len == plen);
        for (i = 0; i < len; i++)
          if (line_buf[i] != pat_byte(i)) full = 1'b0;
        if (full) begin
          for (i = 0; i < rlen; i++) begin
            emit[n] = rep_bytes_m[8*i +: 8];
            n++;
          end
          held_cnt_m = 0;
        end else begin
          // release bytes up to the first start whose tail is still a pattern prefix
          for (s = 0; s < len; s++) begin
            ok = 1'b1;
            for (i = s; i < len; i++)
              if (line_buf[i] != pat_byte(i - s)) ok = 1'b0;
            if (ok) break;
          end
          for (i = 0; i < s; i++) begin
            emit[n] = line_buf[i];
            n++;
          end
          held_cnt_m = len - s;
          for (i = 0; i < held_cnt_m; i++) held_m[i] = line_buf[s + i];
        end
      end
    end
    for (i = 0; i < n; i++) begin
      r.out_byte = emit[i];
      r.last = (i == n - 1);
      expected_bytes_q.push_back(r);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void fail_note(string what, sfr_pkg::rsp_t want, sfr_pkg::rsp_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected byte %02h last %0d, got byte %02h last %0d",
               $realtime, what, want.out_byte, want.last, got.out_byte, got.last);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (req_valid && !req_stall) predict_rewrite(req_data);
      if (!req_valid || !req_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          req_valid <= 1'b0;
        end else if (pending_items_q.size() != 0) begin
          req_data <= pending_items_q.pop_front();
          req_valid <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, armed once
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_armed && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // response monitor and stall generator
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_bytes_q.size() == 0) fail_note("unexpected transaction", '0, rsp_data);
        else if (expected_bytes_q[0] != rsp_data)
          fail_note("mismatch", expected_bytes_q.pop_front(), rsp_data);
        else void'(expected_bytes_q.pop_front());
      end
      if (stall_left != 0) stall_left <= stall_left - 1;
      else stall_left <= pick_gap();
      rsp_stall <= (hold_left != 0) || (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items_q.size() != 0 || req_valid || expected_bytes_q.size() != 0);
    // items that hold bytes produce nothing; let the block finish them
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      sfr_pkg::REG_PATTERN_BYTES: pat_bytes_m = val;
      sfr_pkg::REG_PATTERN_LEN:   pat_len_m = val[3:0];
      sfr_pkg::REG_REPLACE_BYTES: rep_bytes_m = val;
      sfr_pkg::REG_REPLACE_LEN:   rep_len_m = val[3:0];
      default: ;
    endcase
    held_cnt_m = 0;
  endtask

  task automatic program_rewrite(logic [63:0] pat, logic [3:0] plen,
                                 logic [63:0] rep, logic [3:0] rlen);
    wait_idle();
    write_reg(sfr_pkg::REG_PATTERN_BYTES, pat);
    write_reg(sfr_pkg::REG_PATTERN_LEN, {60'd0, plen});
    write_reg(sfr_pkg::REG_REPLACE_BYTES, rep);
    write_reg(sfr_pkg::REG_REPLACE_LEN, {60'd0, rlen});
    @(negedge clk);
  endtask

  function automatic sfr_pkg::req_t text_item(logic [7:0] b);
    sfr_pkg::req_t t;
    t.req_type = sfr_pkg::REQ_DATA;
    t.data_byte = b;
    return t;
  endfunction

  function automatic void queue_flush();
    sfr_pkg::req_t t;
    t.req_type = sfr_pkg::REQ_FLUSH;
    t.data_byte = 8'($urandom_range(0, 255));
    pending_items_q.push_back(t);
  endfunction

  function automatic void queue_string(string s);
    for (int i = 0; i < s.len(); i++) pending_items_q.push_back(text_item(s[i]));
  endfunction

  // text built around the current pattern: full copies, partial prefixes, newlines, noise, flushes
  function automatic void queue_text(int count);
    int made, r, k, plen, j;
    plen = eff_pattern_len();
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        for (j = 0; j < plen; j++) pending_items_q.push_back(text_item(pat_byte(j)));
        made += plen;
      end else if (r < 50) begin
        k = $urandom_range(1, plen);
        for (j = 0; j < k; j++) pending_items_q.push_back(text_item(pat_byte(j)));
        made += k;
      end else if (r < 60) begin
        pending_items_q.push_back(text_item(sfr_pkg::NEWLINE));
        made++;
      end else if (r < 75) begin
        pending_items_q.push_back(text_item(pat_byte($urandom_range(0, plen - 1))));
        made++;
      end else if (r < 95) begin
        pending_items_q.push_back(text_item(8'($urandom_range(0, 255))));
        made++;
      end else begin
        queue_flush();
        made++;
      end
    end
  endfunction

  function automatic logic [63:0] ab_pattern();
    logic [63:0] p;
    for (int i = 0; i < 8; i++)
      p[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'(8'h61 + $urandom_range(0, 1));
    return p;
  endfunction

  initial begin
    logic [63:0] pat, rep;
    logic [3:0]  pl, rl;
    int          count;
    for (int i = 0; i < 8; i++) held_m[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: pattern is a single zero byte, replacement empty
    pending_items_q.push_back(text_item(8'h00));
    pending_items_q.push_back(text_item(8'hFF));
    pending_items_q.push_back(text_item(sfr_pkg::NEWLINE));
    queue_flush();

    // overlapping prefix "aab", replacement length above the maximum
    program_rewrite(64'h0000_0000_0062_6161, 4'd3, 64'h3736_3534_3332_3130, 4'd15);
    queue_string("aaab");
    queue_flush();
    queue_string("a");
    wait_idle();
    // register write while a byte is held drops it; length zero acts as one
    write_reg(sfr_pkg::REG_PATTERN_LEN, 64'd0);
    @(negedge clk);
    queue_string("a");
    queue_flush();

    // newline inside the pattern: straight pass-through
    program_rewrite(64'h0000_0000_0000_0A61, 4'd2, 64'h3736_3534_3332_3130, 4'd15);
    queue_string("a\n");
    queue_flush();

    // pattern equals replacement: silent
    program_rewrite(64'h6261, 4'd2, 64'h6261, 4'd2);
    queue_string("a");
    queue_flush();

    // longest pattern, oversized length field, deleted on match
    program_rewrite(64'h6867_6665_6463_6261, 4'd12, 64'd0, 4'd0);
    queue_string("abcdefgh");
    queue_flush();

    for (int ph = 0; ph < 8; ph++) begin
      pat = ab_pattern();
      rep = {$urandom(), $urandom()};
      pl = 4'($urandom_range(1, 8));
      rl = 4'($urandom_range(0, 8));
      count = 52;
      case (ph)
        0: begin pl = 4'd0; rl = 4'd8; end
        1: begin pat = '1; pl = 4'd15; rep = '0; rl = 4'd0; end
        2: begin pl = 4'($urandom_range(2, 4)); rep = '1; rl = 4'd15; end
        3: begin pat[15:8] = sfr_pkg::NEWLINE; pl = 4'd3; end
        6: begin rep = pat; rl = pl; count = 20; end
        default: ;
      endcase
      program_rewrite(pat, pl, rep, rl);
      quiet = (ph == 5);
      if (ph == 4) hold_armed = 1'b1;
      queue_text(count);
      queue_flush();
    end

    wait_idle();
    if (expected_bytes_q.size() != 0) mismatch_count++;
    if (mismatch_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
